@@ hw/rtl/utt_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Depends on nothing; the front, queue, back and top modules import it.

package utt_pkg;

    // Configuration register indexes on the write port.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b1;
    localparam int unsigned CFG_DATA_W = 31;

    // Lead and continuation byte bounds for strict decoding.
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;
    localparam logic [7:0] F4_CONT_MAX = 8'h8F;

    // Code point limits.
    localparam logic [20:0] MIN_CP2   = 21'h00080;
    localparam logic [20:0] MIN_CP3   = 21'h00800;
    localparam logic [20:0] MIN_CP4   = 21'h10000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h0D800;
    localparam logic [20:0] SURR_HI   = 21'h0DFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Unit counter limits: the counter holds at COUNT_SAT once past COUNT_LIMIT.
    localparam logic [31:0] COUNT_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] COUNT_SAT   = 32'h8000_0000;

    // Depth of the queue between decoder and serializer.
    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned JOB_PTR_W = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic        count_only;
        logic [30:0] capacity;
    } t_cfg;

    // Everything one source byte produces: up to two units and a summary.
    typedef struct packed {
        logic [15:0] unit0;
        logic        unit0_en;
        logic [15:0] unit1;
        logic        unit1_en;
        logic        summ_en;
        t_status     status;
        logic [30:0] count;
    } t_job;

    // Queue status seen by the decoder and the serializer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ hw/rtl/utt_byte_if.sv @@
// Channel carrying source bytes with an end-of-string mark.
// Stand-alone interface; no package needed.

interface utt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

@@ hw/rtl/utt_result_if.sv @@
// Channel carrying UTF-16 units and end-of-string summary transactions.
// Stand-alone interface; no package needed.

interface utt_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit_value;
    logic        is_summary;
    logic [1:0]  status;
    logic [30:0] units_needed;
    logic        last_of_run;

    modport source (output valid, output unit_value, output is_summary, output status,
                    output units_needed, output last_of_run, input ready);
    modport sink   (input valid, input unit_value, input is_summary, input status,
                    input units_needed, input last_of_run, output ready);
endinterface

@@ hw/rtl/utt_front.sv @@
// Decoder front end: accepts one byte per cycle while the queue is not full,
// runs the strict UTF-8 state machine and unit counter, and pushes one job per
// productive byte. Depends on utt_pkg and utt_byte_if.

module utt_front import utt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    utt_byte_if.sink i_byte,
    input  t_qstat i_qstat,
    output logic   o_push,
    output t_job   o_job
);

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_left, n_left;
    logic [2:0]  r_seqlen, n_seqlen;
    logic [7:0]  r_lead, n_lead;
    logic [31:0] r_units;
    logic        r_err, n_err;

    logic        accept;
    logic        eos;
    logic [7:0]  b;
    logic        first;
    logic        emit;
    logic [20:0] cp;
    logic [20:0] v;
    logic [20:0] minimum;
    logic        pair;
    logic [19:0] adj;
    logic [31:0] cap_ext;
    logic [31:0] units_p1, units_p2, sat1, sat2, units_after;

    assign i_byte.ready = ~i_qstat.full;
    assign accept = i_byte.valid & ~i_qstat.full;
    assign eos = i_byte.end_of_string;
    assign b = i_byte.in_byte;

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_seqlen  = r_seqlen;
        n_lead    = r_lead;
        n_err     = r_err;
        emit      = 1'b0;
        cp        = '0;
        v         = {r_partial[14:0], b[5:0]};
        first     = ({1'b0, r_left} == (r_seqlen - 3'd1));
        case (r_seqlen)
            3'd2:    minimum = MIN_CP2;
            3'd3:    minimum = MIN_CP3;
            default: minimum = MIN_CP4;
        endcase
        if (!r_err) begin
            if (r_left == 2'd0) begin
                if (b <= ASCII_MAX) begin
                    emit = 1'b1;
                    cp   = {13'd0, b};
                end else if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
                    n_seqlen  = 3'd2;
                    n_partial = {16'd0, b[4:0]};
                    n_lead    = b;
                    n_left    = 2'd1;
                end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
                    n_seqlen  = 3'd3;
                    n_partial = {17'd0, b[3:0]};
                    n_lead    = b;
                    n_left    = 2'd2;
                end else if (b inside {[LEAD4_MIN:LEAD4_MAX]}) begin
                    n_seqlen  = 3'd4;
                    n_partial = {18'd0, b[2:0]};
                    n_lead    = b;
                    n_left    = 2'd3;
                end else begin
                    n_err = 1'b1;
                end
            end else begin
                if (b[7:6] != 2'b10) begin
                    n_err = 1'b1;
                end else if (first && ((r_lead == LEAD_E0 && b < E0_CONT_MIN) ||
                                       (r_lead == LEAD_ED && b > ED_CONT_MAX) ||
                                       (r_lead == LEAD_F0 && b < F0_CONT_MIN) ||
                                       (r_lead == LEAD_F4 && b > F4_CONT_MAX))) begin
                    n_err = 1'b1;
                end else begin
                    n_partial = v;
                    n_left    = r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        if (v < minimum || v > MAX_CP || (v >= SURR_LO && v <= SURR_HI)) begin
                            n_err = 1'b1;
                        end else begin
                            emit = 1'b1;
                            cp   = v;
                        end
                        n_partial = '0;
                        n_seqlen  = '0;
                        n_lead    = '0;
                    end
                end
            end
            // A sequence still open at the end of the string is truncated.
            if (eos && !n_err && n_left != 2'd0) begin
                n_err = 1'b1;
            end
            if (n_err) begin
                n_partial = '0;
                n_left    = '0;
                n_seqlen  = '0;
                n_lead    = '0;
            end
        end
    end

    // Unit counting; the counter saturates at COUNT_SAT.
    assign cap_ext  = {1'b0, i_cfg.capacity};
    assign units_p1 = r_units + 32'd1;
    assign units_p2 = r_units + 32'd2;
    assign sat1 = r_units[31] ? r_units : units_p1;
    assign sat2 = r_units[31] ? r_units : ((r_units == COUNT_LIMIT) ? COUNT_SAT : units_p2);
    assign pair = (cp[20:16] != 5'd0);
    assign adj  = 20'(cp - SUPP_BASE);
    assign units_after = !emit ? r_units : (pair ? sat2 : sat1);

    always_comb begin
        o_job.unit0    = pair ? (HI_SURR_BASE + {6'd0, adj[19:10]}) : cp[15:0];
        o_job.unit0_en = emit && !i_cfg.count_only && (r_units < cap_ext);
        o_job.unit1    = LO_SURR_BASE + {6'd0, adj[9:0]};
        o_job.unit1_en = emit && pair && !i_cfg.count_only && (sat1 < cap_ext);
        o_job.summ_en  = eos;
        if (n_err) begin
            o_job.status = ST_INVALID;
        end else if (units_after > COUNT_LIMIT) begin
            o_job.status = ST_OVERFLOW;
        end else if (!i_cfg.count_only && units_after > cap_ext) begin
            o_job.status = ST_NO_ROOM;
        end else begin
            o_job.status = ST_OK;
        end
        o_job.count = units_after[31] ? COUNT_LIMIT[30:0] : units_after[30:0];
    end

    assign o_push = accept && (o_job.unit0_en || o_job.unit1_en || o_job.summ_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= '0;
            r_seqlen  <= '0;
            r_lead    <= '0;
            r_units   <= '0;
            r_err     <= 1'b0;
        end else if (accept) begin
            if (eos) begin
                r_partial <= '0;
                r_left    <= '0;
                r_seqlen  <= '0;
                r_lead    <= '0;
                r_units   <= '0;
                r_err     <= 1'b0;
            end else begin
                r_partial <= n_partial;
                r_left    <= n_left;
                r_seqlen  <= n_seqlen;
                r_lead    <= n_lead;
                r_units   <= units_after;
                r_err     <= n_err;
            end
        end
    end

endmodule

@@ hw/rtl/utt_queue.sv @@
// Short job queue between the decoder and the serializer.
// Depends on utt_pkg.

module utt_queue import utt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wptr, r_rptr;
    logic [JOB_PTR_W:0]   r_count, n_count;
    logic                 do_push, do_pop;

    assign o_qstat.full  = (r_count == (JOB_PTR_W + 1)'(JOB_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

@@ hw/rtl/utt_back.sv @@
// Serializer back end: takes jobs from the queue and sends their units and
// summary one transaction per cycle while o_res is ready, through a
// registered output. Depends on utt_pkg and utt_result_if.

module utt_back import utt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  t_qstat i_qstat,
    output logic   o_pop,
    utt_result_if.source o_res
);

    t_job        r_job;
    logic [2:0]  r_mask, n_mask;
    logic        r_out_valid;
    logic [15:0] r_unit;
    logic        r_summ;
    logic [1:0]  r_status;
    logic [30:0] r_count;
    logic        r_last;
    logic        out_free;
    logic        send;

    assign out_free = !r_out_valid || o_res.ready;
    assign send     = out_free && (r_mask != 3'd0);

    // Mask bits: 0 first unit, 1 second unit, 2 summary. Lowest goes first.
    always_comb begin
        n_mask = r_mask;
        if (send) begin
            n_mask = r_mask & (r_mask - 3'd1);
        end
    end

    assign o_pop = !i_qstat.empty && (n_mask == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask <= {i_job.summ_en, i_job.unit1_en, i_job.unit0_en};
            end else begin
                r_mask <= n_mask;
            end
            if (out_free) begin
                r_out_valid <= send;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (send) begin
            r_last <= (n_mask == 3'd0);
            if (r_mask[0]) begin
                r_unit   <= r_job.unit0;
                r_summ   <= 1'b0;
                r_status <= ST_OK;
                r_count  <= '0;
            end else if (r_mask[1]) begin
                r_unit   <= r_job.unit1;
                r_summ   <= 1'b0;
                r_status <= ST_OK;
                r_count  <= '0;
            end else begin
                r_unit   <= '0;
                r_summ   <= 1'b1;
                r_status <= r_job.status;
                r_count  <= r_job.count;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.unit_value   = r_unit;
    assign o_res.is_summary   = r_summ;
    assign o_res.status       = r_status;
    assign o_res.units_needed = r_count;
    assign o_res.last_of_run  = r_last;

endmodule

@@ hw/rtl/utf8_to_utf16_transcoder_top.sv @@
// Top level of the strict UTF-8 to UTF-16 transcoder: configuration
// registers, decoder front end, job queue and serializer back end.
// Depends on utt_pkg, utt_byte_if, utt_result_if, utt_front, utt_queue, utt_back.
//
//   Channel   Direction  Transaction
//   --------  ---------  ---------------------------------------------------
//   i_byte    in         one source byte plus its end-of-string mark
//   o_res     out        one UTF-16 unit, or the end-of-string summary
//   i_cfg_*   in         register write: 0 count_only, 1 output_capacity
//
// The decoder takes one byte per cycle whenever the four-entry job queue has
// room. Each byte yields zero to three result transactions; the serializer
// sends one per cycle while o_res is ready, so a surrogate pair plus summary
// is three sends and the queue absorbs the difference. Each job passes the
// queue, the job register and the output register. Reset is synchronous and
// active low; it sets count_only to 1, output_capacity to 0 and clears
// all string state. A stall on o_res fills the queue and i_byte.ready drops.

module utf8_to_utf16_transcoder_top import utt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    utt_byte_if.sink              i_byte,
    utt_result_if.source          o_res
);

    t_cfg   r_cfg;
    t_job   front_job;
    t_job   queue_job;
    t_qstat qstat;
    logic   push;
    logic   pop;

    // Configuration must be written only between strings (the user's duty; the block
    // leaves it unchecked), so the decoder may read these registers directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_only <= 1'b1;
            r_cfg.capacity   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COUNT_ONLY: r_cfg.count_only <= i_cfg_data[0];
                CFG_CAPACITY:   r_cfg.capacity   <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    utt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_byte  (i_byte),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (front_job)
    );

    utt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_qstat (qstat)
    );

    utt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (queue_job),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
